// File: rtl/core/xdm_pkg.sv
// Shared constants, register codes and the sine series for the X-drive wheel mixer.
`default_nettype none

package xdm_pkg;

  localparam int SINE_TABLE_ENTRIES_DEF = 1024;
  localparam int DUTY_FULL_SCALE_DEF    = 255;

  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_FRONT_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_BACK_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_BACK_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_FRONT_LEFT  = 3'd5;

  localparam logic [DATA_W-1:0] DRIFT_GAIN_RST  = 16'd256;
  localparam logic [DATA_W-1:0] DRIFT_LIMIT_RST = 16'd3277;
  localparam logic [DATA_W-1:0] TRIM_RST        = 16'd32768;

  localparam int WHEELS = 4;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  // heading*N stays below 2^24 over the whole table size range
  localparam int          PHASE_W      = 24;
  localparam int          RECIP_W      = 25;
  localparam logic [24:0] RECIP_3600   = 25'd19088744;
  localparam int          RECIP_SHIFT  = 36;
  localparam logic [11:0] FULL_TURN    = 12'd3600;

  localparam int SC_W      = 17;
  localparam int SC_LAT    = 5;
  localparam int MIX_W     = 36;
  localparam int MAG_W     = 35;
  localparam int QUO_W     = 31;
  localparam int DUTY_LAT  = 3;
  localparam int DUTY_SHIFT = 45;
  localparam int DUTY_SPLIT = 22;

  function automatic logic [15:0] series_q15(longint unsigned x, logic odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned tmp;
    longint          sum;
    begin
      x2   = (x * x) >> 30;
      term = odd ? x : ONE_Q30;
      sum  = longint'(term);
      for (int i = 1; i < 8; i++) begin
        tmp = (term * x2) >> 30;
        if (odd) begin
          case (i)
            1: term = tmp / 6;
            2: term = tmp / 20;
            3: term = tmp / 42;
            4: term = tmp / 72;
            5: term = tmp / 110;
            6: term = tmp / 156;
            default: term = tmp / 210;
          endcase
        end else begin
          case (i)
            1: term = tmp / 2;
            2: term = tmp / 12;
            3: term = tmp / 30;
            4: term = tmp / 56;
            5: term = tmp / 90;
            6: term = tmp / 132;
            default: term = tmp / 182;
          endcase
        end
        if (i % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) sum = 32768;
      series_q15 = 16'(sum);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/x_drive_wheel_mixer.sv
// Top level of the X-drive wheel mixer: drift correction, wheel mixing and output.
//
// Each beat carries a move command (heading, speed, turn rate) and the measured
// acceleration; one result beat gives direction and PWM duty for the four wheels.
// The datapath is a stall-together pipeline of 45 stages: five for the sine/cosine
// lookup, six for velocity, mixing and the largest-magnitude search, 31 for the
// bit-per-stage normalizing divider and three for trim and duty. One beat is taken
// every cycle while no result waits on out_ready, which stalls the whole pipeline.
// Configuration writes are taken at once and must come only while no beat is in
// flight.
`default_nettype none

module x_drive_wheel_mixer #(
  parameter int SINE_TABLE_ENTRIES = xdm_pkg::SINE_TABLE_ENTRIES_DEF,
  parameter int DUTY_FULL_SCALE    = xdm_pkg::DUTY_FULL_SCALE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [xdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [xdm_pkg::DATA_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [11:0]                    heading_tenths,
  input  wire logic [15:0]                    drive_speed,
  input  wire logic signed [16:0]             turn_rate,
  input  wire logic signed [15:0]             accel_right,
  input  wire logic signed [15:0]             accel_forward,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                fr_forward,
  output logic [7:0]                          fr_duty,
  output logic                                br_forward,
  output logic [7:0]                          br_duty,
  output logic                                bl_forward,
  output logic [7:0]                          bl_duty,
  output logic                                fl_forward,
  output logic [7:0]                          fl_duty
);

  localparam int NW      = xdm_pkg::WHEELS;
  localparam int MIX_W   = xdm_pkg::MIX_W;
  localparam int MAG_W   = xdm_pkg::MAG_W;
  localparam int QUO_W   = xdm_pkg::QUO_W;
  localparam int ST_SC   = xdm_pkg::SC_LAT;
  localparam int ST_PROD = ST_SC + 1;
  localparam int ST_VEL  = ST_PROD + 1;
  localparam int ST_MIX  = ST_VEL + 1;
  localparam int ST_MAG  = ST_MIX + 1;
  localparam int ST_PAIR = ST_MAG + 1;
  localparam int ST_MAX  = ST_PAIR + 1;
  localparam int ST_DIV  = ST_MAX + QUO_W;
  localparam int LAT     = ST_DIV + xdm_pkg::DUTY_LAT;
  localparam logic [MAG_W-1:0] ONE = MAG_W'(xdm_pkg::ONE_Q30);

  logic [xdm_pkg::DATA_W-1:0] drift_gain;
  logic [xdm_pkg::DATA_W-1:0] drift_limit;
  logic [xdm_pkg::DATA_W-1:0] trim [NW];

  logic [LAT:1] v;
  logic         en;

  logic [15:0]        spd [1:ST_SC];
  logic signed [32:0] w   [1:ST_VEL];
  logic signed [32:0] prx;
  logic signed [32:0] pry;
  logic signed [31:0] drx [2:ST_PROD];
  logic signed [31:0] dry [2:ST_PROD];
  logic signed [33:0] negx;
  logic signed [33:0] negy;
  logic signed [33:0] lim;
  logic signed [33:0] clx;
  logic signed [33:0] cly;

  logic signed [xdm_pkg::SC_W-1:0] sn;
  logic signed [xdm_pkg::SC_W-1:0] cs;
  logic signed [33:0]       pc;
  logic signed [33:0]       ps;
  logic signed [34:0]       vx;
  logic signed [34:0]       vy;
  logic signed [MIX_W-1:0]  m [NW];
  logic [NW-1:0]            dir_mix;
  logic [NW-1:0]            dir [ST_MIX+1:LAT-1];
  logic [MAG_W-1:0]         mag  [NW];
  logic [MAG_W-1:0]         mag10 [NW];
  logic [MAG_W-1:0]         mag11 [NW];
  logic [MAG_W-1:0]         mx01;
  logic [MAG_W-1:0]         mx23;
  logic [MAG_W-1:0]         maxmag;
  logic [QUO_W-1:0]         quo  [NW];
  logic [7:0]               duty [NW];
  logic [NW-1:0]            fwd;

  assign cfg_ready = 1'b1;
  assign en        = !v[LAT] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_gain  <= xdm_pkg::DRIFT_GAIN_RST;
      drift_limit <= xdm_pkg::DRIFT_LIMIT_RST;
      for (int i = 0; i < NW; i++) trim[i] <= xdm_pkg::TRIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xdm_pkg::REG_DRIFT_GAIN:       drift_gain  <= cfg_data;
        xdm_pkg::REG_DRIFT_LIMIT:      drift_limit <= cfg_data;
        xdm_pkg::REG_TRIM_FRONT_RIGHT: trim[0]     <= cfg_data;
        xdm_pkg::REG_TRIM_BACK_RIGHT:  trim[1]     <= cfg_data;
        xdm_pkg::REG_TRIM_BACK_LEFT:   trim[2]     <= cfg_data;
        xdm_pkg::REG_TRIM_FRONT_LEFT:  trim[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-1:1], in_valid};
    end
  end

  xdm_sincos #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_sincos (
    .clk(clk),
    .en(en),
    .heading(heading_tenths),
    .sn(sn),
    .cs(cs)
  );

  assign lim  = $signed({16'b0, drift_limit, 1'b0});
  assign negx = -34'(prx);
  assign negy = -34'(pry);
  assign clx  = (negx > lim) ? lim : (negx < -lim) ? -lim : negx;
  assign cly  = (negy > lim) ? lim : (negy < -lim) ? -lim : negy;

  // flip front wheels: forward when the mixed value is not positive
  assign dir_mix = {m[3] <= 0, m[2] >= 0, m[1] >= 0, m[0] <= 0};

  always_ff @(posedge clk) begin
    if (en) begin
      spd[1] <= drive_speed;
      w[1]   <= $signed({-($signed({turn_rate[16], turn_rate})), 15'b0});
      prx    <= accel_right * $signed({1'b0, drift_gain});
      pry    <= accel_forward * $signed({1'b0, drift_gain});
      drx[2] <= $signed({clx[17:0], 14'b0});
      dry[2] <= $signed({cly[17:0], 14'b0});
      for (int j = 2; j <= ST_SC; j++) spd[j] <= spd[j-1];
      for (int j = 2; j <= ST_VEL; j++) w[j] <= w[j-1];
      for (int j = 3; j <= ST_PROD; j++) begin
        drx[j] <= drx[j-1];
        dry[j] <= dry[j-1];
      end

      pc <= $signed({1'b0, spd[ST_SC]}) * cs;
      ps <= $signed({1'b0, spd[ST_SC]}) * sn;

      vx <= 35'(pc) + 35'(drx[ST_PROD]);
      vy <= -35'(ps) + 35'(dry[ST_PROD]);

      m[0] <= MIX_W'(vy) + MIX_W'(vx) + MIX_W'(w[ST_VEL]);
      m[1] <= MIX_W'(vy) - MIX_W'(vx) - MIX_W'(w[ST_VEL]);
      m[2] <= MIX_W'(vy) + MIX_W'(vx) - MIX_W'(w[ST_VEL]);
      m[3] <= MIX_W'(vy) - MIX_W'(vx) + MIX_W'(w[ST_VEL]);

      for (int i = 0; i < NW; i++) begin
        mag[i]   <= m[i][MIX_W-1] ? MAG_W'(-m[i]) : MAG_W'(m[i]);
        mag10[i] <= mag[i];
        mag11[i] <= mag10[i];
      end
      dir[ST_MIX + 1] <= dir_mix;
      for (int j = ST_MIX + 2; j < LAT; j++) dir[j] <= dir[j-1];

      mx01 <= (mag[0] > mag[1]) ? mag[0] : mag[1];
      mx23 <= (mag[2] > mag[3]) ? mag[2] : mag[3];
      if (mx01 >= mx23) maxmag <= (mx01 > ONE) ? mx01 : ONE;
      else maxmag <= (mx23 > ONE) ? mx23 : ONE;

      for (int i = 0; i < NW; i++) fwd[i] <= (trim[i] == '0) || dir[LAT-1][i];
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_wheel
    xdm_div #(
      .MAG_W(MAG_W),
      .QUO_W(QUO_W)
    ) u_div (
      .clk(clk),
      .en(en),
      .num(mag11[i]),
      .den(maxmag),
      .quo(quo[i])
    );

    xdm_duty #(
      .DUTY_FULL_SCALE(DUTY_FULL_SCALE),
      .QUO_W(QUO_W)
    ) u_duty (
      .clk(clk),
      .en(en),
      .r30(quo[i]),
      .trim(trim[i]),
      .duty(duty[i])
    );
  end

  assign fr_forward = fwd[0];
  assign br_forward = fwd[1];
  assign bl_forward = fwd[2];
  assign fl_forward = fwd[3];
  assign fr_duty    = duty[0];
  assign br_duty    = duty[1];
  assign bl_duty    = duty[2];
  assign fl_duty    = duty[3];

  localparam logic [15:0] FS16 = 16'(DUTY_FULL_SCALE);

  a_stall_only_on_wait: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no waiting result");

  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    v[ST_MAX] |-> maxmag >= ONE && mag11[0] <= maxmag && mag11[1] <= maxmag &&
                  mag11[2] <= maxmag && mag11[3] <= maxmag)
    else $error("largest magnitude below a wheel magnitude");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    v[ST_DIV] |-> quo[0] <= QUO_W'(ONE) && quo[1] <= QUO_W'(ONE) &&
                  quo[2] <= QUO_W'(ONE) && quo[3] <= QUO_W'(ONE))
    else $error("normalized wheel value above one");

  a_duty_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {8'b0, fr_duty} <= FS16 && {8'b0, br_duty} <= FS16 &&
                  {8'b0, bl_duty} <= FS16 && {8'b0, fl_duty} <= FS16)
    else $error("duty above full scale");

endmodule

`default_nettype wire

// File: rtl/core/xdm_sincos.sv
// Heading to signed Q2.15 sine and cosine: phase scaling, quadrant split and table lookup.
`default_nettype none

module xdm_sincos #(
  parameter int SINE_TABLE_ENTRIES = xdm_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [11:0]                       heading,
  output logic signed [xdm_pkg::SC_W-1:0]        sn,
  output logic signed [xdm_pkg::SC_W-1:0]        cs
);

  localparam int N  = SINE_TABLE_ENTRIES;
  localparam int KW = $clog2(N);
  localparam int PW = xdm_pkg::PHASE_W;
  localparam int MW = PW + xdm_pkg::RECIP_W;
  localparam logic [KW+1:0] N1 = (KW+2)'(N);
  localparam logic [KW+1:0] N2 = (KW+2)'(2 * N);
  localparam logic [KW+1:0] N3 = (KW+2)'(3 * N);

  logic [15:0] sin_tab [N];
  logic [15:0] cos_tab [N];

  for (genvar g = 0; g < N; g++) begin : g_rom
    localparam longint unsigned X =
      (xdm_pkg::HALF_PI_Q30 * longint'(g) * 2 + longint'(N)) / (2 * longint'(N));
    assign sin_tab[g] = xdm_pkg::series_q15(X, 1'b1);
    assign cos_tab[g] = xdm_pkg::series_q15(X, 1'b0);
  end

  logic [11:0]    hw;
  logic [PW-1:0]  phase1;
  logic [KW-1:0]  k2;
  logic [MW-1:0]  kprod;
  logic [KW+1:0]  k4;
  logic [1:0]     q3;
  logic [KW-1:0]  r3;
  logic [1:0]     q4;
  logic [15:0]    s4;
  logic [15:0]    c4;
  logic signed [xdm_pkg::SC_W-1:0] sv;
  logic signed [xdm_pkg::SC_W-1:0] cv;

  assign hw    = (heading >= xdm_pkg::FULL_TURN) ? heading - xdm_pkg::FULL_TURN : heading;
  assign kprod = MW'(phase1) * MW'(xdm_pkg::RECIP_3600);
  assign k4    = {k2, 2'b00};
  assign sv    = $signed({1'b0, s4});
  assign cv    = $signed({1'b0, c4});

  always_ff @(posedge clk) begin
    if (en) begin
      phase1 <= PW'(hw) * PW'(N);
      k2     <= KW'(kprod >> xdm_pkg::RECIP_SHIFT);
      if (k4 >= N3) begin
        q3 <= 2'd3;
        r3 <= KW'(k4 - N3);
      end else if (k4 >= N2) begin
        q3 <= 2'd2;
        r3 <= KW'(k4 - N2);
      end else if (k4 >= N1) begin
        q3 <= 2'd1;
        r3 <= KW'(k4 - N1);
      end else begin
        q3 <= 2'd0;
        r3 <= KW'(k4);
      end
      q4 <= q3;
      s4 <= sin_tab[r3];
      c4 <= cos_tab[r3];
      case (q4)
        2'd0: begin
          sn <= sv;
          cs <= cv;
        end
        2'd1: begin
          sn <= cv;
          cs <= -sv;
        end
        2'd2: begin
          sn <= -sv;
          cs <= -cv;
        end
        default: begin
          sn <= -cv;
          cs <= sv;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/xdm_div.sv
// Pipelined restoring divider, one quotient bit per stage, for wheel normalization.
`default_nettype none

module xdm_div #(
  parameter int MAG_W = xdm_pkg::MAG_W,
  parameter int QUO_W = xdm_pkg::QUO_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [MAG_W-1:0] num,
  input  wire logic [MAG_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  logic [MAG_W-1:0] rem [QUO_W];
  logic [MAG_W-1:0] dv  [QUO_W];
  logic [QUO_W-1:0] qb  [QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (num >= den) begin
        rem[0] <= num - den;
        qb[0]  <= QUO_W'(1);
      end else begin
        rem[0] <= num;
        qb[0]  <= '0;
      end
      dv[0] <= den;
    end
  end

  for (genvar j = 1; j < QUO_W; j++) begin : g_stage
    logic [MAG_W:0] t;
    logic           ge;
    assign t  = {rem[j-1], 1'b0};
    assign ge = t >= {1'b0, dv[j-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? MAG_W'(t - {1'b0, dv[j-1]}) : MAG_W'(t);
        dv[j]  <= dv[j-1];
        qb[j]  <= {qb[j-1][QUO_W-2:0], ge};
      end
    end
  end

  assign quo = qb[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/core/xdm_duty.sv
// Trim scaling and PWM duty with saturation for one wheel.
`default_nettype none

module xdm_duty #(
  parameter int DUTY_FULL_SCALE = xdm_pkg::DUTY_FULL_SCALE_DEF,
  parameter int QUO_W           = xdm_pkg::QUO_W
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [QUO_W-1:0]            r30,
  input  wire logic [xdm_pkg::DATA_W-1:0]  trim,
  output logic      [7:0]                  duty
);

  localparam int PW = QUO_W + xdm_pkg::DATA_W;
  localparam int SH = xdm_pkg::DUTY_SHIFT;
  localparam int SP = xdm_pkg::DUTY_SPLIT;
  localparam int HW = SH - SP + xdm_pkg::DATA_W;
  localparam int LW = SP + xdm_pkg::DATA_W;
  localparam logic [xdm_pkg::DATA_W-1:0] FS = xdm_pkg::DATA_W'(DUTY_FULL_SCALE);

  logic [PW-1:0]  p1;
  logic [HW-1:0]  hip;
  logic [LW-1:0]  lop;
  logic           ovf;
  logic [HW:0]    s;
  logic [HW-(SH-SP):0] d;

  assign s = (HW+1)'(hip) + (HW+1)'(lop >> SP);
  assign d = s[HW:SH-SP];

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= PW'(r30) * PW'(trim);
      hip <= HW'(p1[SH-1:SP]) * HW'(FS);
      lop <= LW'(p1[SP-1:0]) * LW'(FS);
      ovf <= |p1[PW-1:SH];
      if (ovf || d > (HW-(SH-SP)+1)'(FS)) duty <= FS[7:0];
      else duty <= d[7:0];
    end
  end

endmodule

`default_nettype wire
